### sv/lmgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmgs_pkg
// Shared types, codes and search helper for the light mode group selector.
// ----------------------------------------------------------------------------
package lmgs_pkg;

	localparam int REGULAR_MODES    = 8;
	localparam int SPECIAL_MODES    = 4;
	localparam int TICKS_PER_MINUTE = 480;

	localparam int REG_W  = $clog2(REGULAR_MODES);
	localparam int SPC_W  = $clog2(SPECIAL_MODES);
	localparam int TPM_W  = $clog2(TICKS_PER_MINUTE + 1);
	localparam int PROD_W = 8 + TPM_W;

	localparam logic [16:0] TICKS_MAX = 17'h1FFFF;

	localparam logic [3:0] REG_N = 4'(REGULAR_MODES);
	localparam logic [3:0] SPC_N = 4'(SPECIAL_MODES);

	localparam logic [1:0] CFG_ENABLE  = 2'd0;
	localparam logic [1:0] CFG_REG_MIN = 2'd1;
	localparam logic [1:0] CFG_SPC_MIN = 2'd2;
	localparam logic [1:0] CFG_BST_MIN = 2'd3;

	localparam logic [12:0] ENABLE_RESET = 13'd7967;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KEY  = 1'b1;

	localparam logic [2:0] PWR_OFF      = 3'd0;
	localparam logic [2:0] PWR_ON       = 3'd1;
	localparam logic [2:0] PWR_MOMENTARY = 3'd2;
	localparam logic [2:0] PWR_LOCKED   = 3'd3;
	localparam logic [2:0] PWR_ERROR    = 3'd4;

	localparam logic [1:0] GRP_REGULAR = 2'd0;
	localparam logic [1:0] GRP_BOOST   = 2'd1;
	localparam logic [1:0] GRP_SPECIAL = 2'd2;

	localparam logic [1:0] NOTICE_NONE     = 2'd0;
	localparam logic [1:0] NOTICE_ARMED    = 2'd1;
	localparam logic [1:0] NOTICE_DISARMED = 2'd2;

	typedef struct packed {
		logic [12:0] enable_mask;
		logic [63:0] reg_min;
		logic [31:0] spc_min;
		logic [7:0]  bst_min;
	} cfg_t;

	typedef struct packed {
		logic       cmd;
		logic [2:0] press_count;
		logic       hold_level;
		logic [2:0] power_state;
	} item_t;

	typedef struct packed {
		logic        aux_power_enable;
		logic        show_mode_pattern;
		logic [1:0]  timer_notice;
		logic        effects_restart;
		logic        timer_expired;
		logic [16:0] timer_left;
		logic        timer_running;
		logic [2:0]  mode_index;
		logic [1:0]  mode_group;
	} res_t;

	typedef struct packed {
		logic       found;
		logic [2:0] idx;
	} srch_t;

	// rotating search: from pos (step=0) or from pos+1 ending at pos (step=1)
	function automatic srch_t rot_search(input logic [7:0] en, input logic [2:0] pos,
			input logic step, input logic [3:0] n);
		srch_t      r;
		logic [3:0] j;
		r.found = 1'b0;
		r.idx   = pos;
		for (int i = 7; i >= 0; i--) begin
			j = {1'b0, pos} + 4'(i) + {3'b000, step};
			if (j >= n) begin
				j = j - n;
			end
			if ((4'(i) < n) && en[j[2:0]]) begin
				r.found = 1'b1;
				r.idx   = j[2:0];
			end
		end
		return r;
	endfunction

endpackage

### sv/lmgs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmgs_cfg
// Configuration register file: enable mask and auto-off minute tables.
// ----------------------------------------------------------------------------
module lmgs_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output lmgs_pkg::cfg_t      cfg
);
	import lmgs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_mask <= ENABLE_RESET;
			cfg_q.reg_min     <= '0;
			cfg_q.spc_min     <= '0;
			cfg_q.bst_min     <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ENABLE:  cfg_q.enable_mask <= cfg_data[12:0];
				CFG_REG_MIN: cfg_q.reg_min     <= cfg_data;
				CFG_SPC_MIN: cfg_q.spc_min     <= cfg_data[31:0];
				CFG_BST_MIN: cfg_q.bst_min     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/lmgs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmgs_core
// Mode/timer state and the combinational next-state and result logic.
// ----------------------------------------------------------------------------
module lmgs_core (
	input  logic            clk,
	input  logic            arst_n,
	input  lmgs_pkg::cfg_t  cfg,
	input  logic            adv,
	input  lmgs_pkg::item_t item,
	output lmgs_pkg::res_t  res
);
	import lmgs_pkg::*;

	logic [1:0]       group_q;
	logic [REG_W-1:0] rpos_q;
	logic [SPC_W-1:0] spos_q;
	logic             hold_q;
	logic             armed_q;
	logic [16:0]      ticks_q;

	logic [1:0]       n_group;
	logic [REG_W-1:0] n_rpos;
	logic [SPC_W-1:0] n_spos;
	logic             n_hold;
	logic             n_armed;
	logic [16:0]      n_ticks;

	logic [7:0]        mins;
	logic [PROD_W-1:0] prod;
	logic [16:0]       reload;
	logic [7:0]        reg_en;
	logic [7:0]        spc_en;
	srch_t             reg_step, reg_enter, spc_step, spc_enter;
	logic              led_on;
	logic              boost_en;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			reg_en[k] = (k < REGULAR_MODES) && cfg.enable_mask[k];
			spc_en[k] = (k < SPECIAL_MODES) && (k < 4) && cfg.enable_mask[8 + (k % 4)];
		end
	end

	assign boost_en = cfg.enable_mask[12];
	assign led_on   = (item.power_state == PWR_ON) || (item.power_state == PWR_MOMENTARY);

	always_comb begin
		case (group_q)
			GRP_REGULAR: mins = 8'(cfg.reg_min >> {rpos_q, 3'b000});
			GRP_BOOST:   mins = cfg.bst_min;
			default:     mins = 8'(cfg.spc_min >> {spos_q, 3'b000});
		endcase
	end

	assign prod   = PROD_W'(mins) * PROD_W'(TICKS_PER_MINUTE);
	assign reload = (32'(prod) > 32'(TICKS_MAX)) ? TICKS_MAX : 17'(prod);

	assign reg_step  = rot_search(reg_en, 3'(rpos_q), 1'b1, REG_N);
	assign reg_enter = rot_search(reg_en, 3'(rpos_q), 1'b0, REG_N);
	assign spc_step  = rot_search(spc_en, 3'(spos_q), 1'b1, SPC_N);
	assign spc_enter = rot_search(spc_en, 3'(spos_q), 1'b0, SPC_N);

	always_comb begin
		logic do_reg_enter;
		logic do_spc_enter;
		logic do_boost;
		n_group = group_q;
		n_rpos  = rpos_q;
		n_spos  = spos_q;
		n_hold  = hold_q;
		n_armed = armed_q;
		n_ticks = ticks_q;
		do_reg_enter = 1'b0;
		do_spc_enter = 1'b0;
		do_boost     = 1'b0;
		res.effects_restart   = 1'b0;
		res.timer_notice      = NOTICE_NONE;
		res.show_mode_pattern = 1'b0;
		res.aux_power_enable  = 1'b0;

		if (item.cmd == CMD_TICK) begin
			if (led_on && armed_q && (ticks_q != '0)) begin
				n_ticks = ticks_q - 17'd1;
			end
		end else if (!(item.power_state inside {PWR_LOCKED, PWR_ERROR})) begin
			if (item.hold_level != hold_q) begin
				n_hold = item.hold_level;
				if (item.hold_level && (mins != '0)) begin
					if (!armed_q) begin
						n_armed = 1'b1;
						n_ticks = reload;
						res.timer_notice = NOTICE_ARMED;
					end else begin
						n_armed = 1'b0;
						n_ticks = '0;
						res.timer_notice = NOTICE_DISARMED;
					end
				end
			end
			if (item.press_count inside {[3'd1:3'd3]}) begin
				if (n_armed && (n_ticks == '0)) begin
					n_armed = 1'b0;
				end
				if (n_armed) begin
					if (mins != '0) begin
						n_ticks = reload;
					end else begin
						n_armed = 1'b0;
						n_ticks = '0;
					end
				end
				case (group_q)
					GRP_REGULAR: begin
						if (item.press_count == 3'd1) begin
							if (reg_step.found) begin
								n_rpos = REG_W'(reg_step.idx);
							end
						end else if (item.press_count == 3'd2) begin
							do_boost = 1'b1;
						end else begin
							do_spc_enter = 1'b1;
						end
					end
					GRP_BOOST: begin
						if (item.press_count == 3'd3) begin
							do_spc_enter = 1'b1;
						end else begin
							do_reg_enter = 1'b1;
						end
					end
					default: begin
						if (item.press_count == 3'd1) begin
							if (spc_step.found) begin
								n_spos = SPC_W'(spc_step.idx);
							end
						end else if (item.press_count == 3'd2) begin
							do_boost = 1'b1;
						end else begin
							do_reg_enter = 1'b1;
						end
					end
				endcase
				if (do_boost && boost_en) begin
					n_group = GRP_BOOST;
				end
				if (do_reg_enter && reg_enter.found) begin
					n_group = GRP_REGULAR;
					n_rpos  = REG_W'(reg_enter.idx);
				end
				if (do_spc_enter && spc_enter.found) begin
					n_group = GRP_SPECIAL;
					n_spos  = SPC_W'(spc_enter.idx);
				end
				res.effects_restart   = 1'b1;
				res.aux_power_enable  = led_on;
				res.show_mode_pattern = !led_on;
			end
		end

		res.mode_group    = n_group;
		case (n_group)
			GRP_REGULAR: res.mode_index = 3'(n_rpos);
			GRP_SPECIAL: res.mode_index = 3'(n_spos);
			default:     res.mode_index = '0;
		endcase
		res.timer_running = n_armed;
		res.timer_left    = n_ticks;
		res.timer_expired = n_armed && (n_ticks == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= GRP_REGULAR;
			rpos_q  <= '0;
			spos_q  <= '0;
			hold_q  <= 1'b0;
			armed_q <= 1'b0;
			ticks_q <= '0;
		end else if (adv) begin
			group_q <= n_group;
			rpos_q  <= n_rpos;
			spos_q  <= n_spos;
			hold_q  <= n_hold;
			armed_q <= n_armed;
			ticks_q <= n_ticks;
		end
	end

`ifndef SYNTHESIS
	a_disarmed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> (ticks_q == '0))
		else $error("countdown nonzero while disarmed");

	a_ticks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ticks_q) <= ((32'd255 * 32'(TICKS_PER_MINUTE) > 32'(TICKS_MAX)) ?
			32'(TICKS_MAX) : 32'd255 * 32'(TICKS_PER_MINUTE)))
		else $error("countdown above largest reload");

	a_hold_only_keys: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (item.cmd == CMD_TICK)) |=> $stable(hold_q) && $stable(group_q))
		else $error("tick changed hold flag or group");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(group_q) && $stable(ticks_q) && $stable(armed_q))
		else $error("state moved without a transfer");

	a_spos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(spos_q) < SPECIAL_MODES)
		else $error("special index out of range");
`endif

endmodule

### sv/light_mode_group_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_mode_group_selector_unit
// Mode group selector with gesture-armed auto-off countdown for a light driver.
// ----------------------------------------------------------------------------
// Takes one tick or key event per clock and returns one result per event, in
// order. An event is captured in an input register, processed against the
// mode/timer state by combinational logic, and its result held in an output
// register. Throughput is one event per cycle while the result side takes
// transfers; a full output register that is not taken stalls the input side.
// Configuration writes apply on the clock edge where cfg_wr_en is high.
module light_mode_group_selector_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // press_count[2:0], hold_level[3], power_state[6:4]
	input  logic        s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // mode_group[1:0], mode_index[4:2], timer_running[5],
	                                   // timer_left[22:6], timer_expired[23],
	                                   // effects_restart[24], timer_notice[26:25],
	                                   // show_mode_pattern[27], aux_power_enable[28]
);
	import lmgs_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  adv;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	lmgs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.cmd         <= s_axis_tuser;
			item_s1.press_count <= s_axis_tdata[2:0];
			item_s1.hold_level  <= s_axis_tdata[3];
			item_s1.power_state <= s_axis_tdata[6:4];
		end
	end

	lmgs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.adv    (adv),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, res_s2};

endmodule
